// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

   localparam int unsigned MAX_BITS     = 16;
   localparam int unsigned SECTOR_UNITS = 3840;
   localparam int unsigned TURN_UNITS   = 23040;
   localparam int unsigned HUE_BITS     = 15;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2,
      SECTOR_GREY  = 2'd3
   } sector_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } req_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [15:0] saturation;
      logic [15:0] brightness;
   } rsp_type;

   // Classified sample handed from the front part to the back part.
   typedef struct packed {
      sector_type  sector;
      logic [15:0] maxv;
      logic [15:0] delta;
      logic        neg;
      logic [15:0] mag;
   } cls_type;

endpackage

// ===== rtl/rgb_to_hsv_convert.sv =====
// RGB to HSV converter. A transaction is accepted whenever start is high;
// busy is held low, so one sample can enter every clock cycle. Each
// sample's result is shown for one cycle with done high after these
// steps in order: the front register classifies the sample (max, min,
// sector), the queue register holds it, the two pipelined restoring
// dividers run (one quotient bit per stage), and the back part forms the
// hue and registers the result. The receiver cannot stall the block, so
// it must take every result in the cycle it is shown. Hue is in 1/64
// degree (0 to 23039), saturation uses 65535 for 1.0, and brightness is
// the largest channel.
module rgb_to_hsv_convert import rhc_pkg::*; #(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    done,
   output rsp_type rsp_data
);

   logic    f_valid, q_valid_ff;
   cls_type f_data, q_data_ff;

   // The pipeline never blocks, so the block is never busy.
   assign busy = 1'b0;

   rhc_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
      .clock, .reset, .in_valid(start), .in_data(req_data),
      .out_valid(f_valid), .out_data(f_data)
   );

   // One-entry queue register between the front and back parts.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= f_valid;
      end
      q_data_ff <= f_data;
   end

   rhc_back u_back (
      .clock, .reset, .in_valid(q_valid_ff), .in_data(q_data_ff),
      .out_valid(done), .out_data(rsp_data)
   );

endmodule

// ===== rtl/rhc_front.sv =====
module rhc_front import rhc_pkg::*; #(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_data,
   output logic    out_valid,
   output cls_type out_data
);

   logic [CHANNEL_BITS-1:0] r, g, b, mx, mn, da, db;
   logic                    valid_ff;
   cls_type                 data_ff, data_in;

   always_comb begin
      r  = in_data.red[CHANNEL_BITS-1:0];
      g  = in_data.green[CHANNEL_BITS-1:0];
      b  = in_data.blue[CHANNEL_BITS-1:0];
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      data_in.maxv  = 16'(mx);
      data_in.delta = 16'(mx - mn);
      if (mx == mn) begin
         data_in.sector = SECTOR_GREY;
         da = r;
         db = r;
      end else if (mx == r) begin
         data_in.sector = SECTOR_RED;
         da = g;
         db = b;
      end else if (mx == g) begin
         data_in.sector = SECTOR_GREEN;
         da = b;
         db = r;
      end else begin
         data_in.sector = SECTOR_BLUE;
         da = r;
         db = g;
      end
      data_in.neg = (da < db);
      data_in.mag = data_in.neg ? 16'(db - da) : 16'(da - db);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rhc_divider.sv =====
module rhc_divider import rhc_pkg::*; #(
   parameter int unsigned NUM_BITS = 32,
   parameter int unsigned DEN_BITS = 16,
   parameter int unsigned TAG_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  logic [TAG_BITS-1:0] in_tag,
   output logic                out_valid,
   output logic [NUM_BITS-1:0] out_quo,
   output logic [TAG_BITS-1:0] out_tag
);

   // Restoring divider, one quotient bit per pipeline stage.
   localparam int unsigned STAGES = NUM_BITS;

   logic [STAGES:1]           vld_ff;
   logic [NUM_BITS-1:0]       quo_ff [1:STAGES];
   logic [DEN_BITS-1:0]       rem_ff [1:STAGES];
   logic [DEN_BITS-1:0]       den_ff [1:STAGES];
   logic [TAG_BITS-1:0]       tag_ff [1:STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                vld_s;
      logic [NUM_BITS-1:0] quo_s;
      logic [DEN_BITS-1:0] rem_s;
      logic [DEN_BITS-1:0] den_s;
      logic [TAG_BITS-1:0] tag_s;
      logic [DEN_BITS:0]   trial;
      logic [DEN_BITS+1:0] diff;
      if (s == 0) begin : g_first
         assign vld_s = in_valid;
         assign quo_s = in_num;
         assign rem_s = '0;
         assign den_s = in_den;
         assign tag_s = in_tag;
      end else begin : g_next
         assign vld_s = vld_ff[s];
         assign quo_s = quo_ff[s];
         assign rem_s = rem_ff[s];
         assign den_s = den_ff[s];
         assign tag_s = tag_ff[s];
      end
      assign trial = {rem_s, quo_s[NUM_BITS-1]};
      assign diff  = {1'b0, trial} - {2'b00, den_s};
      // The partial remainder is always below the divisor, so it fits.
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_s;
         end
         den_ff[s+1] <= den_s;
         tag_ff[s+1] <= tag_s;
         if (!diff[DEN_BITS+1]) begin
            rem_ff[s+1] <= diff[DEN_BITS-1:0];
            quo_ff[s+1] <= {quo_s[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= trial[DEN_BITS-1:0];
            quo_ff[s+1] <= {quo_s[NUM_BITS-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign out_quo   = quo_ff[STAGES];
   assign out_tag   = tag_ff[STAGES];

endmodule

// ===== rtl/rhc_back.sv =====
module rhc_back import rhc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  cls_type in_data,
   output logic    out_valid,
   output rsp_type out_data
);

   localparam int unsigned SAT_TAG_BITS = 16;
   localparam int unsigned HUE_TAG_BITS = 2 + 1;
   localparam int unsigned QW           = 32;

   logic [QW-1:0]           sat_num, hue_num, sat_q, hue_q;
   logic [SAT_TAG_BITS-1:0] sat_tag, sat_tag_o;
   logic [HUE_TAG_BITS-1:0] hue_tag_in, hue_tag;
   logic                    sat_v, hue_v;
   logic [15:0]             sat_den, hue_den;
   logic [15:0]             mx_o;
   sector_type              sec_o;
   logic                    neg_o;
   logic [15:0]             off;
   logic [HUE_BITS:0]       base, hue_sum;
   logic                    valid_ff;
   rsp_type                 data_ff, data_in;

   // Black samples divide by one; the result is forced to zero afterwards.
   assign sat_den    = (in_data.maxv == '0) ? 16'd1 : in_data.maxv;
   assign sat_num    = QW'(in_data.delta) * QW'(16'hFFFF);
   assign hue_den    = (in_data.delta == '0) ? 16'd1 : in_data.delta;
   assign hue_num    = QW'(in_data.mag) * QW'(SECTOR_UNITS);
   assign sat_tag    = in_data.maxv;
   assign hue_tag_in = {in_data.sector, in_data.neg};

   rhc_divider #(.NUM_BITS(QW), .DEN_BITS(16), .TAG_BITS(SAT_TAG_BITS)) u_sat (
      .clock, .reset, .in_valid(in_valid), .in_num(sat_num), .in_den(sat_den),
      .in_tag(sat_tag), .out_valid(sat_v), .out_quo(sat_q), .out_tag(sat_tag_o)
   );

   rhc_divider #(.NUM_BITS(QW), .DEN_BITS(16), .TAG_BITS(HUE_TAG_BITS)) u_hue (
      .clock, .reset, .in_valid(in_valid), .in_num(hue_num), .in_den(hue_den),
      .in_tag(hue_tag_in), .out_valid(hue_v), .out_quo(hue_q), .out_tag(hue_tag)
   );

   always_comb begin
      sec_o = sector_type'(hue_tag[2:1]);
      neg_o = hue_tag[0];
      mx_o  = sat_tag_o;
      off   = hue_q[15:0];
      case (sec_o)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = (HUE_BITS+1)'(2 * SECTOR_UNITS);
         SECTOR_BLUE:  base = (HUE_BITS+1)'(4 * SECTOR_UNITS);
         default:      base = '0;
      endcase
      if (!neg_o) begin
         hue_sum = base + (HUE_BITS+1)'(off);
      end else if (base >= (HUE_BITS+1)'(off)) begin
         hue_sum = base - (HUE_BITS+1)'(off);
      end else begin
         hue_sum = base + (HUE_BITS+1)'(TURN_UNITS) - (HUE_BITS+1)'(off);
      end
      data_in.hue        = (sec_o == SECTOR_GREY) ? '0 : hue_sum[HUE_BITS-1:0];
      data_in.saturation = (mx_o == '0) ? '0 : sat_q[15:0];
      data_in.brightness = mx_o;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= hue_v & sat_v;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rhc_checker.sv =====
module rhc_checker import rhc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    done,
   input rsp_type rsp_data
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      done |-> (rsp_data.hue < 15'(TURN_UNITS)))
      else $error("hue out of range");
   a_sat_black: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_data.brightness == '0) |-> (rsp_data.saturation == '0))
      else $error("black sample with saturation");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##35 done)
      else $error("result missing");

endmodule

bind rgb_to_hsv_convert rhc_checker u_rhc_checker (
   .clock, .reset, .start, .busy, .done, .rsp_data
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// Testbench for rgb_to_hsv_convert. Every transaction sent to the block has
// its expected hue, saturation and brightness worked out by a predictor in
// this file and queued in order. A monitor compares each result, field by
// field, with the oldest queued expectation. The block keeps no state, so
// the order of transactions matters only for pipeline ordering.
module testbench;
   import rhc_pkg::*;

   localparam int unsigned LATENCY   = 35;
   localparam int unsigned N_RANDOM  = 1450;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    done;
   rsp_type rsp_data;

   rsp_type hsv_expected_q[$];
   int      error_count;
   int      sent_count;
   int      checked_count;
   int      gap_percent;

   rgb_to_hsv_convert dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .done     (done),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block never answers.
   initial begin
      #40ms;
      $display("rgb_to_hsv_convert regression: fail");
      $finish;
   end

   // Predicts hue, saturation and brightness for one sample.
   function automatic rsp_type hsv_of(req_type px);
      rsp_type     res;
      int          r, g, b, mx, mn, delta, diff, hue, base;
      longint      offs;
      sector_type  sec;
      r  = px.red;
      g  = px.green;
      b  = px.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      hue = 0;
      if (delta == 0) begin
         sec = SECTOR_GREY;
      end else if (mx == r) begin
         sec = SECTOR_RED;
      end else if (mx == g) begin
         sec = SECTOR_GREEN;
      end else begin
         sec = SECTOR_BLUE;
      end
      case (sec)
         SECTOR_RED: begin
            base = 0;
            diff = g - b;
         end
         SECTOR_GREEN: begin
            base = 2;
            diff = b - r;
         end
         SECTOR_BLUE: begin
            base = 4;
            diff = r - g;
         end
         default: begin
            base = 0;
            diff = 0;
         end
      endcase
      if (sec != SECTOR_GREY) begin
         // The sector offset is truncated toward zero before wrapping.
         offs = (longint'(SECTOR_UNITS) * (diff < 0 ? -diff : diff)) / delta;
         hue = base * SECTOR_UNITS + (diff < 0 ? -int'(offs) : int'(offs));
         if (hue < 0) hue += TURN_UNITS;
      end
      res.hue        = hue[14:0];
      res.saturation = (mx == 0) ? 16'd0
                                 : 16'((longint'(delta) * 65535) / mx);
      res.brightness = mx[15:0];
      return res;
   endfunction

   // Sends one sample, with a random gap before it when the sender idles.
   task automatic send_sample(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
      req_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      while ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      hsv_expected_q.push_back(hsv_of(px));
      sent_count++;
      // Leave start high; the next call drives it again in its own step.
   endtask

   task automatic release_bus();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      release_bus();
      while (hsv_expected_q.size() != 0) @(posedge clock);
   endtask

   // Monitor: every done cycle carries exactly one result.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && done) begin
         if (hsv_expected_q.size() == 0) begin
            $error("unexpected result hue=%0d sat=%0d val=%0d",
                   rsp_data.hue, rsp_data.saturation, rsp_data.brightness);
            error_count++;
         end else begin
            want = hsv_expected_q.pop_front();
            checked_count++;
            if (rsp_data.hue !== want.hue) begin
               $error("hue: expected %0d, actual %0d", want.hue, rsp_data.hue);
               error_count++;
            end
            if (rsp_data.saturation !== want.saturation) begin
               $error("saturation: expected %0d, actual %0d",
                      want.saturation, rsp_data.saturation);
               error_count++;
            end
            if (rsp_data.brightness !== want.brightness) begin
               $error("brightness: expected %0d, actual %0d",
                      want.brightness, rsp_data.brightness);
               error_count++;
            end
         end
      end
   end

   // Extremes, greys, black, every sector, ties and negative wraps.
   task automatic test_directed();
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'h1234, 16'h1234, 16'h1234);
      send_sample(16'hFFFF, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'hFFFF, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'hFFFF);
      send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
      send_sample(16'h0000, 16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
      send_sample(16'h8000, 16'h0001, 16'h0002);
      send_sample(16'h0003, 16'h0001, 16'h0000);
      send_sample(16'h0003, 16'h0000, 16'h0001);
      send_sample(16'h0001, 16'h0003, 16'h0000);
      send_sample(16'h0000, 16'h0001, 16'h0003);
      send_sample(16'h0001, 16'h0000, 16'h0003);
      send_sample(16'hFFFF, 16'h0000, 16'hFFFE);
      send_sample(16'h0001, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h0001);
      send_sample(16'hAAAA, 16'h5555, 16'h5554);
      send_sample(16'h0007, 16'h0007, 16'h0003);
   endtask

   // Random samples: mostly full-range, some near-grey, some with ties.
   task automatic test_random(input int count);
      logic [15:0] r, g, b;
      repeat (count) begin
         r = 16'($urandom);
         g = 16'($urandom);
         b = 16'($urandom);
         case ($urandom_range(9))
            0: begin
               g = 16'(r + $urandom_range(3) - 1);
               b = 16'(r + $urandom_range(3) - 1);
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4: begin
               r = r >> $urandom_range(15);
               g = g >> $urandom_range(15);
               b = b >> $urandom_range(15);
            end
            default: ;
         endcase
         send_sample(r, g, b);
      end
   endtask

   // The sender stops until all expected results are in, then resumes.
   task automatic test_pause_and_drain();
      test_random(20);
      drain_results();
      test_random(20);
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      error_count = 0;
      sent_count  = 0;
      checked_count = 0;
      gap_percent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_percent = 17;
      test_directed();
      test_random(N_RANDOM / 3);
      test_pause_and_drain();
      gap_percent = 76;
      test_random(N_RANDOM / 3);
      gap_percent = 0;
      test_random(N_RANDOM / 3);

      drain_results();
      repeat (LATENCY + 5) @(posedge clock);
      $display("Sent %0d samples, checked %0d results across all sectors,",
               sent_count, checked_count);
      $display("greys, ties, black and extremes, with and without sender gaps.");
      if (error_count == 0 && hsv_expected_q.size() == 0) begin
         $display("rgb_to_hsv_convert regression: pass");
      end else begin
         $display("rgb_to_hsv_convert regression: fail");
      end
      $finish;
   end

endmodule
